### rtl/upi_pkg.sv
// upi_pkg: shared types and constants of the unicycle pose integrator
// item structs, opcodes, register indexes, controller states and commands
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package upi_pkg;

    localparam int unsigned TURN_BITS = 24;
    localparam int unsigned CFG_IDX_W = 3;

    localparam logic [1:0] OP_JOY     = 2'd0;
    localparam logic [1:0] OP_TICK    = 2'd1;
    localparam logic [1:0] OP_RESTART = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_LIN      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_ANG      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TICK_DT       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_START_X       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_START_Y       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_START_HEADING = 3'd5;

    localparam logic [15:0] GAIN_LIN_RST = 16'd256;
    localparam logic [15:0] GAIN_ANG_RST = 16'd256;
    localparam logic [15:0] TICK_DT_RST  = 16'd655;

    // 2^32 / (2 pi), turns per radian in Q0.32
    localparam logic signed [30:0] INV_TWO_PI_Q32 = 31'sd683565276;
    localparam logic [TURN_BITS-1:0] QUARTER_TURN = 24'h400000;

    typedef struct packed {
        logic [1:0]         opcode;
        logic signed [15:0] axis_lin;
        logic signed [15:0] axis_ang;
    } upi_in_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic [15:0]        heading;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_ang;
    } upi_out_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_JOY0,
        ST_JOY1,
        ST_RESTART,
        ST_TICK0,
        ST_TICK1,
        ST_TICK2,
        ST_TICK3,
        ST_TICK4,
        ST_TICK5,
        ST_FIN0,
        ST_FIN1,
        ST_FIN2,
        ST_FIN3,
        ST_DONE
    } upi_state_t;

    typedef enum logic [3:0] {
        MUL_NONE,
        MUL_LIN_AXIS,
        MUL_ANG_AXIS,
        MUL_DT_VX,
        MUL_DT_VY,
        MUL_DT_ANG,
        MUL_RAD_K,
        MUL_LIN_COS,
        MUL_LIN_SIN
    } upi_mul_t;

    typedef enum logic {
        TRIG_COS,
        TRIG_SIN
    } upi_trig_t;

    typedef struct packed {
        logic      item_load;
        logic      restart;
        upi_mul_t  mul_sel;
        upi_trig_t trig_sel;
        logic      out_load;
    } upi_cmd_t;

    typedef struct packed {
        logic out_full;
    } upi_status_t;

endpackage

`default_nettype wire

### rtl/upi_sine_rom.sv
// upi_sine_rom: quarter-wave sine table with registered lookup
// builds the table at elaboration, folds the angle into the first quadrant
// depends on upi_pkg
`timescale 1ns / 1ps
`default_nettype none

module upi_sine_rom
    import upi_pkg::*;
#(
    parameter int unsigned TAB_BITS = 10
) (
    input  wire logic                  aclk,
    input  wire logic [TURN_BITS-1:0]  angle,
    output logic signed [17:0]         trig_q
);

    localparam int unsigned TAB_N = 1 << TAB_BITS;
    localparam logic [TAB_BITS:0] TAB_N_V = (TAB_BITS + 1)'(TAB_N);
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] Q30_ONE = 64'd1 << 30;

    // odd taylor series to x^11 in q2.30, rounded to q1.16
    function automatic logic [16:0] sine_entry(input int unsigned idx);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] f;
        logic [63:0] s;
        logic [63:0] e;
        x  = (64'(idx) * HALF_PI_Q30) >> TAB_BITS;
        x2 = (x * x) >> 30;
        f  = Q30_ONE;
        f  = Q30_ONE - (((x2 * f) >> 30) / 64'd110);
        f  = Q30_ONE - (((x2 * f) >> 30) / 64'd72);
        f  = Q30_ONE - (((x2 * f) >> 30) / 64'd42);
        f  = Q30_ONE - (((x2 * f) >> 30) / 64'd20);
        f  = Q30_ONE - (((x2 * f) >> 30) / 64'd6);
        s = (x * f) >> 30;
        e = (s + 64'd8192) >> 14;
        if (e > 64'd65536) begin
            e = 64'd65536;
        end
        return e[16:0];
    endfunction

    logic [16:0] rom [0:TAB_N];

    for (genvar g = 0; g <= TAB_N; g++) begin : g_rom
        localparam logic [16:0] ENTRY = sine_entry(g);
        assign rom[g] = ENTRY;
    end

    logic [1:0]          quad;
    logic [TAB_BITS-1:0] low;
    logic [TAB_BITS:0]   rd_idx;
    logic signed [17:0]  mag;
    logic signed [17:0]  trig_next;

    always_comb begin
        quad      = angle[TURN_BITS-1 -: 2];
        low       = angle[TURN_BITS-3 -: TAB_BITS];
        rd_idx    = quad[0] ? (TAB_N_V - {1'b0, low}) : {1'b0, low};
        mag       = signed'({1'b0, rom[rd_idx]});
        trig_next = quad[1] ? -mag : mag;
    end

    always_ff @(posedge aclk) begin
        trig_q <= trig_next;
    end

endmodule

`default_nettype wire

### rtl/upi_ctrl.sv
// upi_ctrl: sequencer of the pose integrator
// steps the shared multiplier and sine lookup per opcode, issues upi_cmd_t
// depends on upi_pkg
`timescale 1ns / 1ps
`default_nettype none

module upi_ctrl
    import upi_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    input  wire logic [1:0]  s_opcode,
    output logic             s_ready,
    input  wire upi_status_t status,
    output upi_cmd_t         cmd
);

    upi_state_t state_reg;
    upi_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    case (s_opcode)
                        OP_JOY:     state_next = ST_JOY0;
                        OP_TICK:    state_next = ST_TICK0;
                        OP_RESTART: state_next = ST_RESTART;
                        default:    state_next = ST_FIN0;
                    endcase
                end
            end
            ST_JOY0:    state_next = ST_JOY1;
            ST_JOY1:    state_next = ST_FIN0;
            ST_RESTART: state_next = ST_FIN0;
            ST_TICK0:   state_next = ST_TICK1;
            ST_TICK1:   state_next = ST_TICK2;
            ST_TICK2:   state_next = ST_TICK3;
            ST_TICK3:   state_next = ST_TICK4;
            ST_TICK4:   state_next = ST_TICK5;
            ST_TICK5:   state_next = ST_FIN0;
            ST_FIN0:    state_next = ST_FIN1;
            ST_FIN1:    state_next = ST_FIN2;
            ST_FIN2:    state_next = ST_FIN3;
            ST_FIN3:    state_next = ST_DONE;
            ST_DONE: begin
                if (!status.out_full) begin
                    state_next = ST_IDLE;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready       = 1'b0;
        cmd.item_load = 1'b0;
        cmd.restart   = 1'b0;
        cmd.mul_sel   = MUL_NONE;
        cmd.trig_sel  = TRIG_COS;
        cmd.out_load  = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready       = 1'b1;
                cmd.item_load = s_valid;
            end
            ST_JOY0:    cmd.mul_sel = MUL_LIN_AXIS;
            ST_JOY1:    cmd.mul_sel = MUL_ANG_AXIS;
            ST_RESTART: cmd.restart = 1'b1;
            ST_TICK0:   cmd.mul_sel = MUL_DT_VX;
            ST_TICK1:   cmd.mul_sel = MUL_DT_VY;
            ST_TICK2:   cmd.mul_sel = MUL_DT_ANG;
            ST_TICK4:   cmd.mul_sel = MUL_RAD_K;
            ST_FIN1: begin
                cmd.trig_sel = TRIG_SIN;
                cmd.mul_sel  = MUL_LIN_COS;
            end
            ST_FIN2:    cmd.mul_sel = MUL_LIN_SIN;
            ST_DONE:    cmd.out_load = !status.out_full;
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/upi_datapath.sv
// upi_datapath: pose state, config registers, shared multiplier, result register
// products are tagged with their destination and written back in the following cycle
// depends on upi_pkg and upi_sine_rom
`timescale 1ns / 1ps
`default_nettype none

module upi_datapath
    import upi_pkg::*;
#(
    parameter int unsigned TAB_BITS = 10
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire upi_cmd_t             cmd,
    output upi_status_t               status,
    input  wire upi_in_t              s_item,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output upi_out_t                  m_item,
    input  wire logic                 cfg_write,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [31:0]          cfg_data
);

    function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
        logic signed [31:0] r;
        if (v > 48'sh0000_7FFF_FFFF) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -48'sh0000_8000_0000) begin
            r = -32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // configuration
    logic [15:0]        gain_lin_reg;
    logic [15:0]        gain_ang_reg;
    logic [15:0]        tick_dt_reg;
    logic signed [31:0] start_x_reg;
    logic signed [31:0] start_y_reg;
    logic [15:0]        start_heading_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_lin_reg      <= GAIN_LIN_RST;
            gain_ang_reg      <= GAIN_ANG_RST;
            tick_dt_reg       <= TICK_DT_RST;
            start_x_reg       <= '0;
            start_y_reg       <= '0;
            start_heading_reg <= '0;
        end else if (cfg_write) begin
            case (cfg_index)
                CFG_GAIN_LIN:      gain_lin_reg      <= cfg_data[15:0];
                CFG_GAIN_ANG:      gain_ang_reg      <= cfg_data[15:0];
                CFG_TICK_DT:       tick_dt_reg       <= cfg_data[15:0];
                CFG_START_X:       start_x_reg       <= cfg_data;
                CFG_START_Y:       start_y_reg       <= cfg_data;
                CFG_START_HEADING: start_heading_reg <= cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    // captured item
    logic signed [15:0] axis_lin_reg;
    logic signed [15:0] axis_ang_reg;

    always_ff @(posedge aclk) begin
        if (cmd.item_load) begin
            axis_lin_reg <= s_item.axis_lin;
            axis_ang_reg <= s_item.axis_ang;
        end
    end

    // pose and speed state, vx/vy are refreshed from lin and turn at the end of every item
    logic signed [31:0]    x_reg,    x_next;
    logic signed [31:0]    y_reg,    y_next;
    logic [TURN_BITS-1:0]  turn_reg, turn_next;
    logic signed [31:0]    lin_reg,  lin_next;
    logic signed [31:0]    ang_reg,  ang_next;
    logic signed [31:0]    vx_reg,   vx_next;
    logic signed [31:0]    vy_reg,   vy_next;
    logic signed [31:0]    rad_reg,  rad_next;
    logic signed [62:0]    prod_reg, prod_next;
    upi_mul_t              tag_reg;

    logic signed [17:0]    trig_q;
    logic [TURN_BITS-1:0]  trig_angle;

    assign trig_angle = (cmd.trig_sel == TRIG_COS) ? turn_reg + QUARTER_TURN : turn_reg;

    upi_sine_rom #(
        .TAB_BITS (TAB_BITS)
    ) u_sine_rom (
        .aclk   (aclk),
        .angle  (trig_angle),
        .trig_q (trig_q)
    );

    // shared multiplier
    logic signed [31:0] mul_a;
    logic signed [30:0] mul_b;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.mul_sel)
            MUL_LIN_AXIS: begin
                mul_a = 32'(axis_lin_reg);
                mul_b = signed'({15'b0, gain_lin_reg});
            end
            MUL_ANG_AXIS: begin
                mul_a = 32'(axis_ang_reg);
                mul_b = signed'({15'b0, gain_ang_reg});
            end
            MUL_DT_VX: begin
                mul_a = vx_reg;
                mul_b = signed'({15'b0, tick_dt_reg});
            end
            MUL_DT_VY: begin
                mul_a = vy_reg;
                mul_b = signed'({15'b0, tick_dt_reg});
            end
            MUL_DT_ANG: begin
                mul_a = ang_reg;
                mul_b = signed'({15'b0, tick_dt_reg});
            end
            MUL_RAD_K: begin
                mul_a = rad_reg;
                mul_b = INV_TWO_PI_Q32;
            end
            MUL_LIN_COS, MUL_LIN_SIN: begin
                mul_a = lin_reg;
                mul_b = 31'(trig_q);
            end
            default: begin
            end
        endcase
        prod_next = mul_a * mul_b;
    end

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
        rad_reg  <= rad_next;
    end

    // writeback of the previous product
    logic signed [47:0] prod_q16;
    logic signed [47:0] x_sum;
    logic signed [47:0] y_sum;

    always_comb begin
        prod_q16  = 48'(prod_reg >>> 16);
        x_sum     = 48'(x_reg) + prod_q16;
        y_sum     = 48'(y_reg) + prod_q16;
        x_next    = x_reg;
        y_next    = y_reg;
        turn_next = turn_reg;
        lin_next  = lin_reg;
        ang_next  = ang_reg;
        vx_next   = vx_reg;
        vy_next   = vy_reg;
        rad_next  = rad_reg;
        case (tag_reg)
            MUL_LIN_AXIS: lin_next  = prod_reg[38:7];
            MUL_ANG_AXIS: ang_next  = prod_reg[38:7];
            MUL_DT_VX:    x_next    = sat32(x_sum);
            MUL_DT_VY:    y_next    = sat32(y_sum);
            MUL_DT_ANG:   rad_next  = prod_reg[47:16];
            MUL_RAD_K:    turn_next = turn_reg + prod_reg[47:24];
            MUL_LIN_COS:  vx_next   = sat32(prod_q16);
            MUL_LIN_SIN:  vy_next   = sat32(prod_q16);
            default: begin
            end
        endcase
        if (cmd.restart) begin
            x_next    = start_x_reg;
            y_next    = start_y_reg;
            turn_next = {start_heading_reg, 8'b0};
            lin_next  = '0;
            ang_next  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag_reg  <= MUL_NONE;
            x_reg    <= '0;
            y_reg    <= '0;
            turn_reg <= '0;
            lin_reg  <= '0;
            ang_reg  <= '0;
            vx_reg   <= '0;
            vy_reg   <= '0;
        end else begin
            tag_reg  <= cmd.mul_sel;
            x_reg    <= x_next;
            y_reg    <= y_next;
            turn_reg <= turn_next;
            lin_reg  <= lin_next;
            ang_reg  <= ang_next;
            vx_reg   <= vx_next;
            vy_reg   <= vy_next;
        end
    end

    // result register
    logic m_valid_reg, m_valid_next;

    assign m_valid_next    = cmd.out_load ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
    assign status.out_full = m_valid_reg && !m_ready;
    assign m_valid         = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_item.pos_x   <= x_reg;
            m_item.pos_y   <= y_reg;
            m_item.heading <= turn_reg[TURN_BITS-1 -: 16];
            m_item.vel_x   <= vx_reg;
            m_item.vel_y   <= vy_reg;
            m_item.vel_ang <= ang_reg;
        end
    end

endmodule

`default_nettype wire

### rtl/unicycle_pose_integrator_top.sv
// Unicycle pose integrator: Euler dead reckoning of x, y and heading in fixed point.
// One item at a time; s_ready is high only while the block is idle. After acceptance the
// controller steps through the states of the opcode, if any, then the finishing states, and
// loads the result in the done state, returning to idle before the next item is taken;
// a waiting result only holds the block if the next one is ready before it leaves.
// The sequence follows from the single shared 32x31 multiplier, each product written back
// in the cycle after it is formed, and the registered quarter-wave sine table lookup.
// Configuration writes are always accepted and must only be made while the block is idle.
// depends on upi_pkg, upi_ctrl, upi_datapath, upi_sine_rom
`timescale 1ns / 1ps
`default_nettype none

module unicycle_pose_integrator_top
    import upi_pkg::*;
#(
    parameter int unsigned SINE_TABLE_BITS = 10
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire upi_in_t              s_item,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output upi_out_t                  m_item,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [31:0]          cfg_data
);

    upi_cmd_t    cmd;
    upi_status_t status;

    assign cfg_ready = 1'b1;

    upi_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_opcode (s_item.opcode),
        .s_ready  (s_ready),
        .status   (status),
        .cmd      (cmd)
    );

    upi_datapath #(
        .TAB_BITS (SINE_TABLE_BITS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while an item is in progress");

    a_result_from_work: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> !$past(s_ready))
        else $error("result offered without an item in progress");

    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

`default_nettype wire
